// ===== hw/rtl/dmad_pkg.sv =====
// ----------------------------------------------------------------------------
// dmad_pkg
// Shared widths and constants of the dual moving average difference block.
// ----------------------------------------------------------------------------
package dmad_pkg;

    localparam int PRICE_W = 16;
    localparam int DAY_W   = 20;
    localparam int FRAC_W  = 8;
    localparam int AVG_W   = 24;
    localparam int GAP_W   = 25;

    localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [AVG_W-1:0]   avg_t;
    typedef logic signed [GAP_W-1:0] gap_t;

endpackage

// ===== hw/rtl/dmad_cell.sv =====
// ----------------------------------------------------------------------------
// dmad_cell
// One slot of the sample delay line, handing its sample on at each shift.
// ----------------------------------------------------------------------------
module dmad_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  dmad_pkg::price_t sample_in,
    output dmad_pkg::price_t sample_out
);

    dmad_pkg::price_t sample_reg;
    dmad_pkg::price_t sample_next;

    always_comb
    begin
        sample_next = shift ? sample_in : sample_reg;
    end

    // history starts as zero samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

// ===== hw/rtl/dmad_mean.sv =====
// ----------------------------------------------------------------------------
// dmad_mean
// Q.8 window mean: sum * 256 / WINDOW by reciprocal multiply, product registered.
// ----------------------------------------------------------------------------
module dmad_mean #(
    parameter int WINDOW = 5,
    parameter int SUM_W  = 19
) (
    input  logic               clk,
    input  logic               load,
    input  logic [SUM_W-1:0]   sum,
    output dmad_pkg::avg_t     average
);

    localparam int LOG_W  = $clog2(WINDOW);
    // dividend is sum * 256, so it has SUM_W + 8 bits
    localparam int SHIFT  = SUM_W + dmad_pkg::FRAC_W + LOG_W;
    localparam int RECIP_W = SUM_W + dmad_pkg::FRAC_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    always_comb
    begin
        product_next = load ? (PROD_W'(sum) * PROD_W'(RECIP)) : product_reg;
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    // low 8 bits of the shift are the implied 256 scale of the dividend
    assign average = product_reg[SHIFT-dmad_pkg::FRAC_W +: dmad_pkg::AVG_W];

endmodule

// ===== hw/rtl/dual_moving_average_difference_top.sv =====
// ----------------------------------------------------------------------------
// dual_moving_average_difference_top
// Short and long simple moving averages of a price stream and their gap.
// ----------------------------------------------------------------------------
//  channel  | valid / stall               | payload
//  ---------+-----------------------------+----------------------------------
//  sample   | sample_valid / sample_stall | price
//  result   | result_valid / result_stall | day_number, short_average,
//           |                             | long_average, average_gap
//
//  one sample per cycle while sample_stall is low; a result is registered after
//  its sample is taken (register stages: sum update, reciprocal multiply, average and gap)
//  the first LONG_WINDOW-1 samples give no result, the sums still run
//  reset clears the delay line, both sums and the day counter at once
//  result_stall holds the three stages; sample_stall rises only when all are full
module dual_moving_average_difference_top #(
    parameter int SHORT_WINDOW = 5,
    parameter int LONG_WINDOW  = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic [15:0]               price,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [19:0]               day_number,
    output logic [23:0]               short_average,
    output logic [23:0]               long_average,
    output logic signed [24:0]        average_gap
);

    localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int SHORT_SUM_W = dmad_pkg::PRICE_W + $clog2(SHORT_WINDOW);
    localparam int LONG_SUM_W  = dmad_pkg::PRICE_W + $clog2(LONG_WINDOW);

    // ---- handshake across the stages
    logic rdy1, rdy2, rdy3, accept, load2, load3;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic result_valid_reg, result_valid_next;

    assign rdy3   = !result_valid_reg || !result_stall;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign accept = sample_valid && rdy1;
    assign load2  = v1_reg && rdy2;
    assign load3  = v2_reg && rdy3;

    // ---- delay line, newest sample in cell 0
    dmad_pkg::price_t hist [HIST_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < HIST_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                dmad_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (accept),
                    .sample_in  (price),
                    .sample_out (hist[gi])
                );
            end
            else
            begin : g_body
                dmad_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (accept),
                    .sample_in  (hist[gi-1]),
                    .sample_out (hist[gi])
                );
            end
        end
    endgenerate

    // ---- running sums and day counter
    logic [SHORT_SUM_W-1:0] short_sum_reg, short_sum_next;
    logic [LONG_SUM_W-1:0]  long_sum_reg, long_sum_next;
    dmad_pkg::day_t         day_reg, day_next;
    dmad_pkg::day_t         day_inc;
    logic                   emit;

    always_comb
    begin
        day_inc = (day_reg == dmad_pkg::DAY_MAX) ? day_reg : day_reg + 1'b1;
        emit    = (day_inc >= dmad_pkg::DAY_W'(LONG_WINDOW));
        if (accept)
        begin
            short_sum_next = short_sum_reg - SHORT_SUM_W'(hist[SHORT_WINDOW-1])
                             + SHORT_SUM_W'(price);
            long_sum_next  = long_sum_reg - LONG_SUM_W'(hist[LONG_WINDOW-1])
                             + LONG_SUM_W'(price);
            day_next       = day_inc;
        end
        else
        begin
            short_sum_next = short_sum_reg;
            long_sum_next  = long_sum_reg;
            day_next       = day_reg;
        end
        v1_next           = rdy1 ? (accept && emit) : v1_reg;
        v2_next           = rdy2 ? v1_reg : v2_reg;
        result_valid_next = rdy3 ? v2_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_sum_reg    <= '0;
            long_sum_reg     <= '0;
            day_reg          <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            short_sum_reg    <= short_sum_next;
            long_sum_reg     <= long_sum_next;
            day_reg          <= day_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ---- stage 2: reciprocal multiply
    dmad_pkg::avg_t short_avg, long_avg;
    dmad_pkg::day_t day2_reg, day2_next;

    dmad_mean #(
        .WINDOW (SHORT_WINDOW),
        .SUM_W  (SHORT_SUM_W)
    ) u_short_mean (
        .clk     (clk),
        .load    (load2),
        .sum     (short_sum_reg),
        .average (short_avg)
    );

    dmad_mean #(
        .WINDOW (LONG_WINDOW),
        .SUM_W  (LONG_SUM_W)
    ) u_long_mean (
        .clk     (clk),
        .load    (load2),
        .sum     (long_sum_reg),
        .average (long_avg)
    );

    // ---- stage 3: output register
    dmad_pkg::day_t day3_reg, day3_next;
    dmad_pkg::avg_t short_avg_reg, short_avg_next;
    dmad_pkg::avg_t long_avg_reg, long_avg_next;
    dmad_pkg::gap_t gap_reg, gap_next;

    always_comb
    begin
        day2_next = load2 ? day_reg : day2_reg;
        if (load3)
        begin
            day3_next      = day2_reg;
            short_avg_next = short_avg;
            long_avg_next  = long_avg;
            gap_next       = dmad_pkg::gap_t'({1'b0, short_avg}) -
                             dmad_pkg::gap_t'({1'b0, long_avg});
        end
        else
        begin
            day3_next      = day3_reg;
            short_avg_next = short_avg_reg;
            long_avg_next  = long_avg_reg;
            gap_next       = gap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        day2_reg      <= day2_next;
        day3_reg      <= day3_next;
        short_avg_reg <= short_avg_next;
        long_avg_reg  <= long_avg_next;
        gap_reg       <= gap_next;
    end

    assign sample_stall  = !rdy1;
    assign result_valid  = result_valid_reg;
    assign day_number    = day3_reg;
    assign short_average = short_avg_reg;
    assign long_average  = long_avg_reg;
    assign average_gap   = gap_reg;

endmodule

// ===== hw/rtl/dmad_checker.sv =====
// ----------------------------------------------------------------------------
// dmad_checker
// Port-level checks of the dual moving average difference block.
// ----------------------------------------------------------------------------
module dmad_checker #(
    parameter int LONG_WINDOW = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [19:0]        day_number,
    input  logic [23:0]        short_average,
    input  logic [23:0]        long_average,
    input  logic signed [24:0] average_gap
);

    // a stalled result stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(day_number) && $stable(average_gap))
        else $error("stalled result changed");

    // no result before the long window has filled
    a_warm_up: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> day_number >= 20'(LONG_WINDOW))
        else $error("result during warm-up");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> average_gap == ($signed({1'b0, short_average}) -
                                         $signed({1'b0, long_average})))
        else $error("gap does not match the averages");

endmodule

bind dual_moving_average_difference_top dmad_checker #(
    .LONG_WINDOW (LONG_WINDOW)
) u_dmad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .day_number    (day_number),
    .short_average (short_average),
    .long_average  (long_average),
    .average_gap   (average_gap)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the dual moving average difference block. A queue-fed driver
// sends price samples with random gaps and a monitor takes results with
// random stalls. Every result is checked against an in-bench running-sum
// predictor. The run covers warm-up and extreme prices.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHORT_LEN  = 5;
    localparam int LONG_LEN   = 20;
    localparam int HIST_LEN   = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int MAX_IDLE   = 11;
    localparam int RANDOM_CNT = 500;

    typedef struct {
        dmad_pkg::price_t value;
        int unsigned      idle;
    } sample_t;

    typedef struct {
        dmad_pkg::day_t day;
        dmad_pkg::avg_t short_avg;
        dmad_pkg::avg_t long_avg;
        dmad_pkg::gap_t gap;
    } averages_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    dmad_pkg::price_t price        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    dmad_pkg::day_t   day_number;
    dmad_pkg::avg_t   short_average;
    dmad_pkg::avg_t   long_average;
    dmad_pkg::gap_t   average_gap;

    sample_t     pending_prices[$];
    averages_t   expected_averages[$];
    int unsigned error_count   = 0;
    int unsigned queued_total  = 0;
    bit          tx_idle_on    = 1'b0;
    bit          rx_stall_on   = 1'b0;

    // predictor state
    dmad_pkg::price_t price_history[HIST_LEN] = '{default: '0};
    int unsigned      hist_wr       = 0;
    logic [31:0]      short_total   = '0;
    logic [31:0]      long_total    = '0;
    dmad_pkg::day_t   days_seen     = '0;

    // driver state
    sample_t     staged;
    bit          staged_ok     = 1'b0;
    // monitor state
    int unsigned rx_hold       = 0;

    dual_moving_average_difference_top #(
        .SHORT_WINDOW (SHORT_LEN),
        .LONG_WINDOW  (LONG_LEN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .price         (price),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .day_number    (day_number),
        .short_average (short_average),
        .long_average  (long_average),
        .average_gap   (average_gap)
    );

    always #5 clk = ~clk;

    function automatic dmad_pkg::avg_t q8_mean(input logic [31:0] total,
                                               input int unsigned len);
        logic [63:0] scaled;
        begin
            scaled = {32'd0, total} << 8;
            return dmad_pkg::avg_t'(scaled / 64'(len));
        end
    endfunction

    // update the running sums with one sample, queue the result if past warm-up
    function automatic void advance_averages(input dmad_pkg::price_t p);
        averages_t r;
        int unsigned leave_s;
        int unsigned leave_l;
        begin
            leave_s = (hist_wr + HIST_LEN - SHORT_LEN) % HIST_LEN;
            leave_l = (hist_wr + HIST_LEN - LONG_LEN) % HIST_LEN;
            short_total = short_total - 32'(price_history[leave_s]) + 32'(p);
            long_total  = long_total - 32'(price_history[leave_l]) + 32'(p);
            price_history[hist_wr] = p;
            hist_wr = (hist_wr + 1) % HIST_LEN;
            if (days_seen != dmad_pkg::DAY_MAX)
                days_seen = days_seen + 1'b1;
            if (days_seen >= LONG_LEN)
            begin
                r.day       = days_seen;
                r.short_avg = q8_mean(short_total, SHORT_LEN);
                r.long_avg  = q8_mean(long_total, LONG_LEN);
                r.gap       = dmad_pkg::gap_t'({1'b0, r.short_avg} - {1'b0, r.long_avg});
                expected_averages.push_back(r);
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        begin
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            price        <= '0;
            staged_ok    = 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                advance_averages(price);
            if (!(sample_valid && sample_stall))
            begin
                if (!staged_ok && pending_prices.size() > 0)
                begin
                    staged    = pending_prices.pop_front();
                    staged_ok = 1'b1;
                end
                if (staged_ok && staged.idle == 0)
                begin
                    sample_valid <= 1'b1;
                    price        <= staged.value;
                    staged_ok    = 1'b0;
                end
                else
                begin
                    sample_valid <= 1'b0;
                    if (staged_ok)
                        staged.idle--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        averages_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("unexpected result transaction: day_number 0x%0h", day_number);
                    error_count++;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    compare_field("day_number", 32'(want.day), 32'(day_number));
                    compare_field("short_average", 32'(want.short_avg),
                                  32'(short_average));
                    compare_field("long_average", 32'(want.long_avg), 32'(long_average));
                    compare_field("average_gap", {7'd0, want.gap}, {7'd0, average_gap});
                end
                rx_hold = rx_stall_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_hold > 0)
            begin
                result_stall <= 1'b1;
                rx_hold--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic queue_price(input dmad_pkg::price_t p);
        sample_t s;
        begin
            s.value = p;
            s.idle  = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            pending_prices.push_back(s);
            queued_total++;
        end
    endtask

    function automatic dmad_pkg::price_t random_price();
        begin
            case ($urandom_range(0, 3))
                0:       return dmad_pkg::price_t'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                1:       return dmad_pkg::price_t'(16'hFFFF - $urandom_range(0, 15));
                2:       return dmad_pkg::price_t'($urandom_range(0, 15));
                default: return dmad_pkg::price_t'($urandom);
            endcase
        end
    endfunction

    task automatic wait_all_taken();
        begin
            @(negedge clk);
            while (pending_prices.size() > 0 || staged_ok || sample_valid)
                @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        begin
            wait_all_taken();
            while (expected_averages.size() > 0)
                @(negedge clk);
        end
    endtask

    // idling mode changes per segment, including stretches with none
    task automatic pick_idle_mode();
        int unsigned mode;
        begin
            mode        = $urandom_range(0, 3);
            tx_idle_on  = mode[0];
            rx_stall_on = mode[1];
        end
    endtask

    initial
    begin : stimulus
        int unsigned seg_len;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full-scale window, then the short window drops to zero
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        repeat (20) queue_price(16'hFFFF);
        repeat (5) queue_price(16'h0000);

        // hold the sender until every result is back
        wait_all_results();
        repeat (5) @(negedge clk);

        while (queued_total < 25 + RANDOM_CNT)
        begin
            pick_idle_mode();
            seg_len = $urandom_range(20, 60);
            repeat (seg_len) queue_price(random_price());
            wait_all_taken();
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
